// ----- design/pic_pkg.sv -----
// Shared constants, codes and types for the primitive point containment pipeline.
package pic_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int COORD_FRAC_BITS = 12;

  localparam int MAG_W  = COORD_WIDTH;
  localparam int SQ_W   = 2 * COORD_WIDTH - 1;
  localparam int XY_W   = 2 * COORD_WIDTH;
  localparam int SUM3_W = 2 * COORD_WIDTH;
  localparam int A_W    = SUM3_W + 1;
  localparam int RAD_W  = 16;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int S_W    = (A_W > RSQ_W) ? A_W : RSQ_W;
  localparam int SL_W   = S_W / 2;
  localparam int SH_W   = S_W - SL_W;
  localparam int LHS_W  = 2 * S_W;
  localparam int XY4_W  = XY_W + 2;
  localparam int D_W    = COORD_FRAC_BITS + 2;
  localparam int D2_W   = 2 * D_W;

  localparam logic [MAG_W-1:0]  ONE  = MAG_W'(1) << COORD_FRAC_BITS;
  localparam logic [SUM3_W-1:0] ONE2 = SUM3_W'(1) << (2 * COORD_FRAC_BITS);

  localparam int N_STAGES = 7;

  localparam int SHAPE_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [SHAPE_W-1:0] PRIM_SPHERE   = 3'd0;
  localparam logic [SHAPE_W-1:0] PRIM_CUBE     = 3'd1;
  localparam logic [SHAPE_W-1:0] PRIM_CYLINDER = 3'd2;
  localparam logic [SHAPE_W-1:0] PRIM_CONE     = 3'd3;
  localparam logic [SHAPE_W-1:0] PRIM_TORUS    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_KIND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TUBE_RADIUS = 1'b1;

  localparam logic [SHAPE_W-1:0] SHAPE_RESET  = PRIM_SPHERE;
  localparam logic [RAD_W-1:0]   RADIUS_RESET = 16'd4096;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [N_STAGES-1:0] en;
  } pipe_ctrl_t;

  // Squares and per-axis flags handed from the front end to the evaluation stages.
  typedef struct packed {
    logic [SQ_W-1:0] x2;
    logic [SQ_W-1:0] y2;
    logic [SQ_W-1:0] z2;
    logic [D_W-1:0]  d;
    logic            az_le_one;
    logic            cube_in;
  } sq_t;

endpackage

// ----- design/pic_ctrl.sv -----
// Valid tracking and stall propagation for the seven-stage pipeline.
module pic_ctrl import pic_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output pipe_ctrl_t ctrl
);

  logic [N_STAGES-1:0] vld_r;
  logic [N_STAGES-1:0] vld_nxt;
  logic [N_STAGES-1:0] rdy;

  // A stage can load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[N_STAGES-1] = !vld_r[N_STAGES-1] || !out_stall;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < N_STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctrl.en   = rdy;
  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[N_STAGES-1];

endmodule

// ----- design/pic_magsq.sv -----
// Front end: coordinate magnitudes, then squares and per-axis bound checks.
module pic_magsq import pic_pkg::*; (
  input  logic                          clk,
  input  pipe_ctrl_t                    ctrl,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  output sq_t                           sq
);

  function automatic logic [MAG_W-1:0] mag(input logic [COORD_WIDTH-1:0] v);
    logic [MAG_W-1:0] r;
    r = v[COORD_WIDTH-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  logic [MAG_W-1:0]   ax_r, ay_r, az_r;
  logic               zneg_r;
  logic [2*MAG_W-1:0] x2_full, y2_full, z2_full;
  logic [D_W-1:0]     d_nxt;
  sq_t                sq_r;
  sq_t                sq_nxt;

  // Stage 1: magnitudes. The most negative code has magnitude 2^(width-1),
  // which still fits unsigned.
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      ax_r   <= mag(pos_x);
      ay_r   <= mag(pos_y);
      az_r   <= mag(pos_z);
      zneg_r <= pos_z[COORD_WIDTH-1];
    end
  end

  // Stage 2: squares and the cone's (1 - z) term. The truncation of d only
  // matters when |z| > 1, where the cone test fails anyway.
  always_comb begin
    x2_full = ax_r * ax_r;
    y2_full = ay_r * ay_r;
    z2_full = az_r * az_r;
    d_nxt   = zneg_r ? (D_W'(ONE) + D_W'(az_r)) : (D_W'(ONE) - D_W'(az_r));
    sq_nxt.x2        = x2_full[SQ_W-1:0];
    sq_nxt.y2        = y2_full[SQ_W-1:0];
    sq_nxt.z2        = z2_full[SQ_W-1:0];
    sq_nxt.d         = d_nxt;
    sq_nxt.az_le_one = (az_r <= ONE);
    sq_nxt.cube_in   = (ax_r <= ONE) && (ay_r <= ONE) && (az_r <= ONE);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

// ----- design/pic_eval.sv -----
// Back end: sums, shape comparisons, the split torus square and the result select.
module pic_eval import pic_pkg::*; (
  input  logic               clk,
  input  pipe_ctrl_t         ctrl,
  input  sq_t                sq,
  input  logic [SHAPE_W-1:0] shape_kind,
  input  logic [RAD_W-1:0]   tube_radius,
  output logic               inside_res
);

  typedef struct packed {
    logic sphere;
    logic cube;
    logic cyl;
    logic cone;
  } flags_t;

  logic [RSQ_W-1:0]  rsq_r;

  // Stage 3
  logic [XY_W-1:0]   xy_r;
  logic [SUM3_W-1:0] sum3_r;
  logic [D2_W-1:0]   d2_r;
  logic              az_le_one_r;
  logic              cube_in_r;

  // Stage 4
  logic [A_W-1:0]    a_val;
  logic [S_W-1:0]    a_ext, b_ext;
  flags_t            fl4_r, fl4_nxt;
  logic [S_W-1:0]    s_r;
  logic [XY4_W-1:0]  xy4_r;

  // Stage 5
  logic [SH_W-1:0]      s_hi;
  logic [SL_W-1:0]      s_lo;
  logic [2*SH_W-1:0]    hh_r;
  logic [SH_W+SL_W-1:0] hl_r;
  logic [2*SL_W-1:0]    ll_r;
  flags_t               fl5_r;
  logic [XY4_W-1:0]     xy4_5_r;

  // Stage 6
  logic [LHS_W-1:0]  lhs_r;
  flags_t            fl6_r;
  logic [XY4_W-1:0]  xy4_6_r;

  // Stage 7
  logic              torus_in;
  logic              inside_r, inside_nxt;

  // The user must change the radius only while the pipeline is empty; the block does not
  // enforce this. Its square is simply recomputed every cycle.
  always_ff @(posedge clk) begin
    rsq_r <= tube_radius * tube_radius;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      xy_r        <= XY_W'(sq.x2) + XY_W'(sq.y2);
      sum3_r      <= SUM3_W'(sq.x2) + SUM3_W'(sq.y2) + SUM3_W'(sq.z2);
      d2_r        <= sq.d * sq.d;
      az_le_one_r <= sq.az_le_one;
      cube_in_r   <= sq.cube_in;
    end
  end

  always_comb begin
    a_val          = A_W'(sum3_r) + A_W'(ONE2);
    a_ext          = S_W'(a_val);
    b_ext          = S_W'(rsq_r);
    fl4_nxt.sphere = (sum3_r <= ONE2);
    fl4_nxt.cube   = cube_in_r;
    fl4_nxt.cyl    = az_le_one_r && (SUM3_W'(xy_r) <= ONE2);
    // 4(x^2+y^2) <= d^2 is the same as x^2+y^2 <= floor(d^2/4).
    fl4_nxt.cone   = az_le_one_r && ({xy_r, 2'b00} <= XY4_W'(d2_r));
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      fl4_r <= fl4_nxt;
      s_r   <= (a_ext >= b_ext) ? (a_ext - b_ext) : (b_ext - a_ext);
      xy4_r <= {xy_r, 2'b00};
    end
  end

  // The square of s is built from three partial products of its halves.
  assign s_hi = s_r[S_W-1:SL_W];
  assign s_lo = s_r[SL_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      hh_r    <= s_hi * s_hi;
      hl_r    <= s_hi * s_lo;
      ll_r    <= s_lo * s_lo;
      fl5_r   <= fl4_r;
      xy4_5_r <= xy4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      lhs_r   <= (LHS_W'(hh_r) << (2 * SL_W)) + (LHS_W'(hl_r) << (SL_W + 1))
                 + LHS_W'(ll_r);
      fl6_r   <= fl5_r;
      xy4_6_r <= xy4_5_r;
    end
  end

  assign torus_in = (lhs_r <= LHS_W'(xy4_6_r));

  always_comb begin
    case (shape_kind)
      PRIM_SPHERE:   inside_nxt = fl6_r.sphere;
      PRIM_CUBE:     inside_nxt = fl6_r.cube;
      PRIM_CYLINDER: inside_nxt = fl6_r.cyl;
      PRIM_CONE:     inside_nxt = fl6_r.cone;
      PRIM_TORUS:    inside_nxt = torus_in;
      default:       inside_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[6]) begin
      inside_r <= inside_nxt;
    end
  end

  assign inside_res = inside_r;

endmodule

// ----- design/primitive_point_inside_test_core.sv -----
// Top level of the point containment test against a configurable unit primitive.
//
// This block takes one point per transfer, as three signed Q4.12 coordinates in its
// primitive's canonical space, and returns one bit per point that says whether the
// point lies inside or on the selected unit primitive: sphere, cube, cylinder, cone
// or a torus whose tube radius is programmed in unsigned Q4.12. All squares, sums
// and the torus product are carried at full width, so every comparison is exact.
// The block is a seven-stage pipeline. While the output is not stalled, a new point
// can be accepted in every cycle, so the sustained rate is one point per clock. The
// pipeline depth is set by the torus test, whose square of a 33-bit difference is
// split into partial products over two stages before the final compare. Valid bits
// travel with each stage, so empty stages close up behind a stalled result and the
// input keeps taking points until the pipeline is really full. Shape codes 5 to 7
// select no primitive and always report outside. Configuration writes take effect at
// once and are meant to be issued only while no point is in flight; there is no
// read-back and no clearing pass after reset.
module primitive_point_inside_test_core import pic_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_inside_res,

  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  logic [SHAPE_W-1:0] shape_kind_r;
  logic [RAD_W-1:0]   tube_radius_r;
  pipe_ctrl_t         ctrl;
  sq_t                sq;

  // Configuration registers. The index is one bit wide, so every write lands
  // on one of the two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_kind_r  <= SHAPE_RESET;
      tube_radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SHAPE_KIND:  shape_kind_r  <= cfg_wdata[SHAPE_W-1:0];
        CFG_TUBE_RADIUS: tube_radius_r <= cfg_wdata[RAD_W-1:0];
        default:         shape_kind_r  <= shape_kind_r;
      endcase
    end
  end

  // Stage valids and the stall chain back to the input.
  pic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // Stages one and two: magnitudes, squares and the axis bounds.
  pic_magsq u_magsq (
    .clk   (clk),
    .ctrl  (ctrl),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .pos_z (in_pos_z),
    .sq    (sq)
  );

  // Stages three to seven: shape tests and the registered result.
  pic_eval u_eval (
    .clk         (clk),
    .ctrl        (ctrl),
    .sq          (sq),
    .shape_kind  (shape_kind_r),
    .tube_radius (tube_radius_r),
    .inside_res  (out_inside_res)
  );

endmodule

// ----- design/pic_checker.sv -----
// Port-level checks for the point containment core, bound to its top level.
module pic_checker import pic_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_inside_res,
  input logic                 cfg_wr_en,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [SHAPE_W-1:0] shape_sh_r;

  // Shadow copy of the shape register, taken from the write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_sh_r <= SHAPE_RESET;
    end else if (cfg_wr_en && (cfg_index == CFG_SHAPE_KIND)) begin
      shape_sh_r <= cfg_wdata[SHAPE_W-1:0];
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_inside_res)))
    else $error("stalled result changed");

  // The input only stalls when the pipeline is backed up by a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // Unused shape codes never report a point inside.
  a_unused_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (shape_sh_r > PRIM_TORUS)) |-> !out_inside_res)
    else $error("inside reported for an unused shape code");

endmodule

bind primitive_point_inside_test_core pic_checker u_pic_checker (.*);

// ----- bench/primitive_point_inside_test_core_test.sv -----
// Self-checking bench for the primitive point containment pipeline.
`timescale 1ns / 100ps

module primitive_point_inside_test_core_test;
  import pic_pkg::*;

  // Shape codes that select no primitive; the block must answer outside for them.
  localparam logic [SHAPE_W-1:0] SHAPE_SPARE_LO  = 3'd5;
  localparam logic [SHAPE_W-1:0] SHAPE_SPARE_MID = 3'd6;
  localparam logic [SHAPE_W-1:0] SHAPE_SPARE_HI  = 3'd7;

  localparam int  PHASE_COUNT      = 12;
  localparam int  POINTS_PER_PHASE = 75;
  localparam int  HOLD_CYCLES      = 150;
  localparam int  MAX_IDLE         = 19;
  localparam int  REPORT_LIMIT     = 100;
  // Slowest correct run is roughly 1000 points with idling on both sides; this is
  // ten times its run time and more.
  localparam time RUN_LIMIT        = 10_000_000;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [COORD_WIDTH-1:0] in_pos_x;
  logic signed [COORD_WIDTH-1:0] in_pos_y;
  logic signed [COORD_WIDTH-1:0] in_pos_z;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_inside_res;
  logic                          cfg_wr_en;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;

  // One point in flight and the verdict it must produce.
  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic [SHAPE_W-1:0]            shape;
    logic [RAD_W-1:0]              radius;
    logic                          hit;
  } verdict_t;

  verdict_t            pending_verdicts[$];
  logic [SHAPE_W-1:0]  shape_setting;
  logic [RAD_W-1:0]    radius_setting;
  int                  error_count = 0;
  bit                  sender_gappy;
  bit                  receiver_gappy;
  logic                receiver_hold;

  primitive_point_inside_test_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Exact containment predictor. Every square, sum and the torus product are held
  // in 128 bits, which is far wider than any intermediate can grow, so all of the
  // comparisons below are exact just like in the hardware.
  function automatic logic point_is_inside(input logic signed [COORD_WIDTH-1:0] px,
                                           input logic signed [COORD_WIDTH-1:0] py,
                                           input logic signed [COORD_WIDTH-1:0] pz,
                                           input logic [SHAPE_W-1:0] shape,
                                           input logic [RAD_W-1:0] radius);
    longint     sx, sy, sz;
    bit [127:0] ax, ay, az, unit, unit_sq, xy, sum3, span, shifted, r_sq, dev;
    sx = px;
    sy = py;
    sz = pz;
    ax = 128'(sx < 0 ? -sx : sx);
    ay = 128'(sy < 0 ? -sy : sy);
    az = 128'(sz < 0 ? -sz : sz);
    unit    = 128'(1) << COORD_FRAC_BITS;
    unit_sq = unit * unit;
    xy      = ax * ax + ay * ay;
    sum3    = xy + az * az;
    case (shape)
      PRIM_SPHERE:   return sum3 <= unit_sq;
      PRIM_CUBE:     return ax <= unit && ay <= unit && az <= unit;
      PRIM_CYLINDER: return az <= unit && xy <= unit_sq;
      PRIM_CONE: begin
        if (az > unit) return 1'b0;
        // The cone narrows toward +z, so the radius term grows with a negative z.
        span = (sz < 0) ? unit + az : unit - az;
        return xy <= ((span * span) >> 2);
      end
      PRIM_TORUS: begin
        shifted = sum3 + unit_sq;
        r_sq    = 128'(radius) * 128'(radius);
        dev     = (shifted >= r_sq) ? shifted - r_sq : r_sq - shifted;
        return dev * dev <= (xy << 2);
      end
      default:       return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Offers one point, after a random pause when the sender is gappy, and waits for its
  // transfer. The valid is left high afterwards so back-to-back points see no bubble.
  task automatic send_point(input logic signed [COORD_WIDTH-1:0] px,
                            input logic signed [COORD_WIDTH-1:0] py,
                            input logic signed [COORD_WIDTH-1:0] pz);
    int       pause;
    verdict_t entry;
    pause = sender_gappy ? $urandom_range(0, MAX_IDLE) : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    do @(posedge clk); while (in_stall);
    entry.x      = px;
    entry.y      = py;
    entry.z      = pz;
    entry.shape  = shape_setting;
    entry.radius = radius_setting;
    entry.hit    = point_is_inside(px, py, pz, shape_setting, radius_setting);
    pending_verdicts.push_back(entry);
  endtask

  // Stops offering points and waits until every verdict has come back, then waits longer
  // than the pipeline depth so nothing is left inside the pipeline.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (N_STAGES + 2) @(posedge clk);
  endtask

  // Writes the shape register, then the radius register. The shape word may carry
  // junk above its three bits; the block must ignore it.
  task automatic set_primitive(input logic [CFG_DATA_W-1:0] shape_word,
                               input logic [CFG_DATA_W-1:0] radius_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SHAPE_KIND;
    cfg_wdata <= shape_word;
    @(posedge clk);
    cfg_index <= CFG_TUBE_RADIUS;
    cfg_wdata <= radius_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shape_setting  = shape_word[SHAPE_W-1:0];
    radius_setting = radius_word[RAD_W-1:0];
  endtask

  // Coordinates mostly near the unit region so the verdicts are mixed, with
  // a share of full-range values, near-boundary values and the extremes.
  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 12000)) - 6000;
      6, 7:             v = int'($urandom);
      8: begin
        v = 4096 + int'($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
    endcase
    return COORD_WIDTH'(v);
  endfunction

  // Builds a point close to the torus surface for the given tube radius. Random
  // points almost never land in the thin shell, so this keeps the inside verdicts
  // coming. Returns 0 when the radius has no usable shell in range.
  function automatic bit torus_shell_point(input logic [RAD_W-1:0] radius,
                                           output logic signed [COORD_WIDTH-1:0] px,
                                           output logic signed [COORD_WIDTH-1:0] py,
                                           output logic signed [COORD_WIDTH-1:0] pz);
    longint target, rest;
    int     xs, ys, zs;
    target = longint'(radius) * longint'(radius) - (longint'(1) << (2 * COORD_FRAC_BITS));
    ys = int'($urandom_range(0, 128)) - 64;
    zs = int'($urandom_range(0, 16)) - 8;
    rest = target - longint'(ys * ys) - longint'(zs * zs);
    px = '0;
    py = '0;
    pz = '0;
    if (rest <= 0 || rest > longint'(32767) * 32767) return 1'b0;
    xs = int'($sqrt(real'(rest))) + int'($urandom_range(0, 2)) - 1;
    if (xs > 32767) xs = 32767;
    if ($urandom_range(0, 1) == 1) xs = -xs;
    px = COORD_WIDTH'(xs);
    py = COORD_WIDTH'(ys);
    pz = COORD_WIDTH'(zs);
    return 1'b1;
  endfunction

  function automatic logic [SHAPE_W-1:0] shape_for_phase(input int phase);
    case (phase)
      0:       return PRIM_SPHERE;
      1:       return PRIM_CUBE;
      2:       return PRIM_CYLINDER;
      3:       return PRIM_CONE;
      4:       return PRIM_TORUS;
      5:       return SHAPE_SPARE_LO;
      6:       return SHAPE_SPARE_MID;
      7:       return SHAPE_SPARE_HI;
      8:       return PRIM_TORUS;
      9:       return PRIM_CONE;
      10:      return PRIM_CYLINDER;
      default: return PRIM_SPHERE;
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius();
    case ($urandom_range(0, 5))
      0:       return RAD_W'(1);
      1:       return '1;
      2:       return RADIUS_RESET;
      3:       return RAD_W'($urandom_range(4200, 33000));
      4:       return RAD_W'($urandom);
      default: return RAD_W'($urandom_range(0, 4096));
    endcase
  endfunction

  // The registers come out of reset as a unit sphere; nothing is written here.
  task automatic test_reset_defaults();
    send_point(0, 0, 0);
    send_point(4096, 0, 0);
    send_point(0, 0, -4097);
    send_point(-32768, -32768, -32768);
    send_point(32767, 32767, 32767);
  endtask

  task automatic test_cube();
    drain_pipeline();
    // Junk in the upper bits of the shape word must be ignored.
    set_primitive({13'h1FFF, PRIM_CUBE}, RADIUS_RESET);
    send_point(4096, -4096, 4096);
    send_point(4096, 4097, 0);
    send_point(-32768, 0, 0);
  endtask

  task automatic test_cylinder();
    drain_pipeline();
    set_primitive(CFG_DATA_W'(PRIM_CYLINDER), RADIUS_RESET);
    send_point(0, -4096, 4096);
    send_point(2897, 2897, -4096);
    send_point(0, 0, -4097);
  endtask

  // Apex at z = +1, base of radius 1 at z = -1.
  task automatic test_cone();
    drain_pipeline();
    set_primitive(CFG_DATA_W'(PRIM_CONE), RADIUS_RESET);
    send_point(0, 0, 4096);
    send_point(-4096, 0, -4096);
    send_point(2048, 0, 0);
    send_point(2049, 0, 0);
    send_point(0, 0, 4097);
  endtask

  // Covers the default radius, the zero radius that the torus formula still
  // evaluates as given, and the largest radius.
  task automatic test_torus();
    drain_pipeline();
    set_primitive(CFG_DATA_W'(PRIM_TORUS), RADIUS_RESET);
    send_point(64, 0, 0);
    send_point(0, 0, 0);
    drain_pipeline();
    set_primitive(CFG_DATA_W'(PRIM_TORUS), '0);
    send_point(4096, 0, 0);
    drain_pipeline();
    set_primitive(CFG_DATA_W'(PRIM_TORUS), '1);
    send_point(32767, -32768, 0);
  endtask

  // Shape codes past the torus select nothing, so even the origin is outside.
  task automatic test_unused_shapes();
    drain_pipeline();
    set_primitive(CFG_DATA_W'(SHAPE_SPARE_LO), RADIUS_RESET);
    send_point(0, 0, 0);
    drain_pipeline();
    set_primitive(CFG_DATA_W'(SHAPE_SPARE_HI), RADIUS_RESET);
    send_point(0, 0, 0);
  endtask

  // The receiver stalls for a long stretch while points keep coming, so the
  // pipeline fills and the block has to hold its input off.
  task automatic test_backpressure();
    drain_pipeline();
    set_primitive(CFG_DATA_W'(PRIM_SPHERE), RADIUS_RESET);
    sender_gappy = 1'b0;
    receiver_hold <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
      end
      begin
        repeat (40) send_point(pick_coord(), pick_coord(), pick_coord());
      end
    join
  endtask

  // Several phases, each with its own shape, radius and idling pattern. The
  // first phase runs without any idling on either side.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0]         shape_word;
    logic signed [COORD_WIDTH-1:0] px, py, pz;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_pipeline();
      shape_word = CFG_DATA_W'($urandom);
      shape_word[SHAPE_W-1:0] = shape_for_phase(phase);
      set_primitive(shape_word, pick_radius());
      sender_gappy   = (phase != 0) && ($urandom_range(0, 3) != 0);
      receiver_gappy = (phase != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        if (shape_setting == PRIM_TORUS && $urandom_range(0, 2) == 0 &&
            torus_shell_point(radius_setting, px, py, pz)) begin
          send_point(px, py, pz);
        end else begin
          send_point(pick_coord(), pick_coord(), pick_coord());
        end
      end
    end
  endtask

  // Result side: checks every transfer against the oldest pending verdict and
  // draws a fresh stall length after each one.
  initial begin
    int       stall_left;
    verdict_t want;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result transfer with no point in flight");
        end else begin
          want = pending_verdicts.pop_front();
          if (out_inside_res !== want.hit) begin
            report_mismatch($sformatf(
              "inside_res %b, want %b: point (%0d,%0d,%0d) shape %0d radius %0d",
              out_inside_res, want.hit, want.x, want.y, want.z, want.shape,
              want.radius));
          end
        end
        stall_left = receiver_gappy ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= receiver_hold || (stall_left > 0);
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_pos_x      <= '0;
    in_pos_y      <= '0;
    in_pos_z      <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_SHAPE_KIND;
    cfg_wdata     <= '0;
    receiver_hold <= 1'b0;
    shape_setting  = SHAPE_RESET;
    radius_setting = RADIUS_RESET;
    sender_gappy   = 1'b1;
    receiver_gappy = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_cube();
    test_cylinder();
    test_cone();
    test_torus();
    test_unused_shapes();
    test_backpressure();
    test_random_traffic();

    drain_pipeline();
    repeat (2 * N_STAGES) @(posedge clk);
    if (error_count == 0) begin
      $display("** primitive_point_inside_test_core: PASSED **");
    end else begin
      $display("** primitive_point_inside_test_core: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("** primitive_point_inside_test_core: FAILED **");
    $finish;
  end

endmodule
